>>> design/tle_pkg.sv
// shared types, character codes and a helper for the line discipline
package tle_pkg;

  // default line store depth
  localparam int unsigned LINE_DEPTH_DEF = 64;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_FS     = 8'd28;
  localparam logic [7:0] CH_SP     = 8'd32;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CARET_OFS = 8'd64;

  // result kinds
  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_RDATA   = 2'd1;
  localparam logic [1:0] KIND_REFUSED = 2'd2;

  // input command codes
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // operation handed from front to back
  typedef enum logic [1:0] {
    OP_READ,
    OP_STORE,
    OP_ECHO,
    OP_ERASE
  } tle_op_e;

  // back sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_ERASE_WAIT,
    ST_EMIT
  } tle_state_e;

  // classified command with its echo bytes
  typedef struct packed {
    tle_op_e    op;
    logic [7:0] ch;
    logic [1:0] echo_len;
    logic [7:0] echo0;
    logic [7:0] echo1;
    logic [7:0] echo2;
  } tle_cmd_t;

  // control bytes: below space or with the top bit set
  function automatic logic is_control(input logic [7:0] b);
    return (b < CH_SP) || b[7];
  endfunction

endpackage

>>> design/tle_front.sv
// front end: accepts items, classifies them and queues commands for the back end
module tle_front import tle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output tle_cmd_t   cmd_o
);

  logic     echo_en_q;
  tle_cmd_t cls;
  logic [7:0] ch;
  logic [7:0] caret_ch;

  tle_cmd_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  // echo enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      echo_en_q <= cfg_wdata_i;
    end
  end

  // classify the item and prepare its echo bytes
  always_comb begin
    ch       = (rx_byte_i == CH_CR) ? CH_LF : rx_byte_i;
    caret_ch = ch + CARET_OFS;
    cls          = '0;
    cls.ch       = ch;
    if (command_i == CMD_READ) begin
      cls.op = OP_READ;
    end else if (!echo_en_q) begin
      cls.op = OP_STORE;
    end else if (ch == CH_BS || ch == CH_DEL) begin
      cls.op = OP_ERASE;
    end else begin
      cls.op = OP_ECHO;
      if (ch == CH_LF) begin
        cls.echo_len = 2'd2;
        cls.echo0    = CH_CR;
        cls.echo1    = CH_LF;
      end else if (ch == CH_NUL) begin
        cls.echo_len = 2'd2;
        cls.echo0    = CH_CARET;
        cls.echo1    = CH_ZERO;
      end else if (ch == CH_FS) begin
        cls.echo_len = 2'd2;
        cls.echo0    = CH_CARET;
        cls.echo1    = CH_BSLASH;
      end else if (is_control(ch)) begin
        cls.echo0 = CH_CARET;
        if (caret_ch == CH_LF) begin
          // caret form that lands on LF goes out as caret, CR, LF
          cls.echo_len = 2'd3;
          cls.echo1    = CH_CR;
          cls.echo2    = CH_LF;
        end else begin
          cls.echo_len = 2'd2;
          cls.echo1    = caret_ch;
        end
      end else begin
        cls.echo_len = 2'd1;
        cls.echo0    = ch;
      end
    end
  end

  // two-entry command queue
  assign full        = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

>>> design/tle_back.sv
// back end: line store, pointers and counts, result sequencer and output register
module tle_back import tle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  tle_cmd_t   cmd_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic       last_o
);

  localparam int unsigned PTR_W = $clog2(LINE_DEPTH);
  localparam int unsigned CNT_W = $clog2(LINE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(LINE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LINE_DEPTH);

  tle_state_e state_q, state_d;
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d, prev_ptr;
  logic [CNT_W-1:0] held_q, held_d, nl_q, nl_d;

  logic [7:0] seq_q [6];
  logic [7:0] seq_d [6];
  logic [2:0] seq_cnt_q, seq_cnt_d;
  logic [1:0] seq_kind_q, seq_kind_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] out_kind_q;
  logic [7:0] out_data_q;
  logic       out_last_q;
  logic       out_load, pop_ok;

  logic [7:0]       mem_q [LINE_DEPTH];
  logic [7:0]       mem_rdata_q;
  logic [PTR_W-1:0] mem_raddr;
  logic             mem_we;
  logic [7:0]       mem_wdata;

  assign prev_ptr = (wp_q == '0) ? LAST_PTR : wp_q - 1'b1;
  assign pop_ok   = pop && out_valid_q;
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || pop);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    held_d      = held_q;
    nl_d        = nl_q;
    seq_d       = seq_q;
    seq_cnt_d   = seq_cnt_q;
    seq_kind_d  = seq_kind_q;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = cmd_i.ch;
    mem_raddr   = (cmd_i.op == OP_READ) ? rp_q : prev_ptr;

    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_READ: begin
              if (nl_q != '0 && held_q != '0) begin
                state_d = ST_READ_WAIT;
              end else begin
                seq_d[0]   = CH_NUL;
                seq_kind_d = KIND_REFUSED;
                seq_cnt_d  = 3'd1;
                state_d    = ST_EMIT;
              end
            end
            OP_ERASE: begin
              if (held_q != '0) begin
                state_d = ST_ERASE_WAIT;
              end
            end
            OP_STORE, OP_ECHO: begin
              // store the byte unless the line store is full
              if (held_q != DEPTH_CNT) begin
                mem_we = 1'b1;
                wp_d   = (wp_q == LAST_PTR) ? '0 : wp_q + 1'b1;
                held_d = held_q + 1'b1;
                if (cmd_i.ch == CH_LF) begin
                  nl_d = nl_q + 1'b1;
                end
              end
              if (cmd_i.op == OP_ECHO) begin
                seq_d[0]   = cmd_i.echo0;
                seq_d[1]   = cmd_i.echo1;
                seq_d[2]   = cmd_i.echo2;
                seq_kind_d = KIND_TX;
                seq_cnt_d  = {1'b0, cmd_i.echo_len};
                state_d    = ST_EMIT;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_READ_WAIT: begin
        rp_d   = (rp_q == LAST_PTR) ? '0 : rp_q + 1'b1;
        held_d = held_q - 1'b1;
        if (mem_rdata_q == CH_LF) begin
          nl_d = nl_q - 1'b1;
        end
        seq_d[0]   = mem_rdata_q;
        seq_kind_d = KIND_RDATA;
        seq_cnt_d  = 3'd1;
        state_d    = ST_EMIT;
      end

      ST_ERASE_WAIT: begin
        // a held newline is never erased
        if (mem_rdata_q == CH_LF) begin
          state_d = ST_IDLE;
        end else begin
          wp_d       = prev_ptr;
          held_d     = held_q - 1'b1;
          seq_kind_d = KIND_TX;
          state_d    = ST_EMIT;
          if (is_control(mem_rdata_q)) begin
            seq_d     = '{CH_BS, CH_BS, CH_SP, CH_SP, CH_BS, CH_BS};
            seq_cnt_d = 3'd6;
          end else begin
            seq_d[0]  = CH_BS;
            seq_d[1]  = CH_SP;
            seq_d[2]  = CH_BS;
            seq_cnt_d = 3'd3;
          end
        end
      end

      ST_EMIT: begin
        // shift one result into the output register per transfer slot
        if (out_load) begin
          for (int i = 0; i < 5; i++) begin
            seq_d[i] = seq_q[i+1];
          end
          seq_d[5]  = CH_NUL;
          seq_cnt_d = seq_cnt_q - 3'd1;
          if (seq_cnt_q == 3'd1) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      held_q      <= '0;
      nl_q        <= '0;
      seq_cnt_q   <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      held_q      <= held_d;
      nl_q        <= nl_d;
      seq_cnt_q   <= seq_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop_ok) begin
      out_valid_d = 1'b0;
    end
  end

  // sequence and output payload
  always_ff @(posedge clk_i) begin
    seq_q      <= seq_d;
    seq_kind_q <= seq_kind_d;
    if (out_load) begin
      out_kind_q <= seq_kind_q;
      out_data_q <= seq_q[0];
      out_last_q <= (seq_cnt_q == 3'd1);
    end
  end

  // line store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  assign empty       = !out_valid_q;
  assign kind_o      = out_kind_q;
  assign data_byte_o = out_data_q;
  assign last_o      = out_last_q;

endmodule

>>> design/terminal_line_edit_echo.sv
// top level of the terminal line discipline with echo and line editing
//
//  channel   direction  handshake         payload
//  input     in         push / full       command_i, rx_byte_i
//  result    out        empty / pop       kind_o, data_byte_o, last_o
//  config    in         cfg_we_i          cfg_wdata_i (echo enable)
//
// an item waits in the front queue, then the back sequencer takes its command,
// does a registered store read first for reads and erases, and then shifts
// its results one by one into the output register
// results leave through a one-entry output register; a stalled pop holds the
// sequencer, and the two-entry front queue keeps taking items until full
// reset clears pointers, counts and queues and sets echo on; the line store
// needs no clearing pass
module terminal_line_edit_echo import tle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  logic     cmd_valid;
  logic     cmd_ready;
  tle_cmd_t cmd;

  // accept and classify
  tle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .command_i   (command_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // line store and result sequencing
  tle_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o)
  );

endmodule
